### hdl/lpd_pkg.sv
// shared types, constants and helpers of the length prefix stream deframer
// no dependencies
package lpd_pkg;

  // payload length field width; prefix values must fit in this many bits
  localparam int LENGTH_BITS = 24;
  localparam int PREFIX_BYTES = 4;

  typedef logic [2:0] count_t;
  typedef logic [LENGTH_BITS-1:0] len_t;

  // prefix_count value meaning the prefix is done and payload bytes follow
  localparam count_t PAYLOAD_PHASE = count_t'(PREFIX_BYTES);
  localparam logic [1:0] LAST_PREFIX_POS = 2'(PREFIX_BYTES - 1);

  typedef struct packed {
    logic [7:0] out_byte;
    logic       in_prefix;
    logic       frame_start;
    logic       frame_end;
    len_t       frame_length;
    logic       malformed;
  } result_t;

  // true if prefix byte pos (0 = most significant) has a bit at or above LENGTH_BITS
  function automatic logic byte_too_big(logic [1:0] pos, logic [7:0] b);
    int   lo;
    logic r;
    lo = 24 - 8 * int'(pos);
    if (LENGTH_BITS <= lo) begin
      r = (b != 8'd0);
    end else if (LENGTH_BITS >= lo + 8) begin
      r = 1'b0;
    end else begin
      r = ((b >> (LENGTH_BITS - lo)) != 8'd0);
    end
    return r;
  endfunction

endpackage

### hdl/lpd_if.sv
// valid/ready channel interfaces for the deframer input bytes and results
// depends on lpd_pkg
interface lpd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface lpd_res_if;
  import lpd_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       in_prefix;
  logic       frame_start;
  logic       frame_end;
  len_t       frame_length;
  logic       malformed;

  modport source (output valid, output out_byte, output in_prefix, output frame_start,
                  output frame_end, output frame_length, output malformed, input ready);
  modport sink (input valid, input out_byte, input in_prefix, input frame_start,
                input frame_end, input frame_length, input malformed, output ready);
endinterface

### hdl/lpd_frame_tracker.sv
// framing state: prefix position, length assembly, payload countdown, sticky error
// depends on lpd_pkg
module lpd_frame_tracker
  import lpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output logic       emit,
  output result_t    result
);

  count_t prefix_count, prefix_count_next;
  len_t   length_accum, length_accum_next;
  len_t   payload_left, payload_left_next;
  logic   broken, broken_next;

  logic [1:0] pos;
  len_t       acc_base;
  len_t       acc_new;
  len_t       left_dec;

  assign pos      = prefix_count[1:0];
  assign acc_base = (pos == 2'd0) ? '0 : length_accum;
  assign acc_new  = {acc_base[LENGTH_BITS-9:0], rx_byte};
  assign left_dec = payload_left - len_t'(1);

  always_comb begin
    prefix_count_next = prefix_count;
    length_accum_next = length_accum;
    payload_left_next = payload_left;
    broken_next       = broken;
    emit              = !broken;
    result            = '0;
    result.out_byte   = rx_byte;

    if (!broken) begin
      if (prefix_count < PAYLOAD_PHASE) begin
        result.in_prefix   = 1'b1;
        result.frame_start = (pos == 2'd0);
        if (byte_too_big(pos, rx_byte)) begin
          result.malformed  = 1'b1;
          broken_next       = 1'b1;
          prefix_count_next = '0;
          length_accum_next = '0;
          payload_left_next = '0;
        end else begin
          length_accum_next = acc_new;
          if (pos == LAST_PREFIX_POS) begin
            result.frame_length = acc_new;
            payload_left_next   = acc_new;
            if (acc_new == '0) begin
              result.frame_end  = 1'b1;
              prefix_count_next = '0;
            end else begin
              prefix_count_next = PAYLOAD_PHASE;
            end
          end else begin
            prefix_count_next = prefix_count + count_t'(1);
          end
        end
      end else begin
        result.frame_length = length_accum;
        payload_left_next   = left_dec;
        if (left_dec == '0) begin
          result.frame_end  = 1'b1;
          prefix_count_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_count <= '0;
      length_accum <= '0;
      payload_left <= '0;
      broken       <= 1'b0;
    end else if (accept) begin
      prefix_count <= prefix_count_next;
      length_accum <= length_accum_next;
      payload_left <= payload_left_next;
      broken       <= broken_next;
    end
  end

endmodule

### hdl/length_prefix_stream_deframer_top.sv
// top level of the length prefix stream deframer: framing tracker plus result register
// depends on lpd_pkg, lpd_if and lpd_frame_tracker
//
// Splits a byte stream into messages, each a four-byte big-endian length
// prefix followed by that many payload bytes. Every byte comes back out with
// markers: in_prefix on the four prefix bytes, frame_start on the first one,
// frame_end on the last byte of the message (the last prefix byte when the
// length is zero), and frame_length from the last prefix byte onward. The
// length must fit in 24 bits, so a nonzero first prefix byte is malformed: that
// byte is returned with malformed set and frame_length zero, and from then on
// every byte is taken and dropped with no result until reset. Throughput is one
// byte per clock, each result registered; the only limit is the single result
// register, which takes a new byte whenever it is empty or being drained in the
// same cycle.
module length_prefix_stream_deframer_top
  import lpd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  lpd_rx_if.sink    rx,
  lpd_res_if.source res
);

  logic    accept;
  logic    emit;
  result_t result;

  // result register
  logic    out_valid;
  result_t out_data;

  // take a byte whenever the result register is free or drains this cycle
  assign rx.ready = !out_valid || res.ready;
  assign accept   = rx.valid && rx.ready;

  lpd_frame_tracker u_tracker (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx.rx_byte),
    .emit    (emit),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      // dropped bytes after an error leave the register empty
      out_valid <= emit;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload only; qualified by out_valid
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_data <= result;
    end
  end

  assign res.valid        = out_valid;
  assign res.out_byte     = out_data.out_byte;
  assign res.in_prefix    = out_data.in_prefix;
  assign res.frame_start  = out_data.frame_start;
  assign res.frame_end    = out_data.frame_end;
  assign res.frame_length = out_data.frame_length;
  assign res.malformed    = out_data.malformed;

  // an error result is always a prefix byte with no length and no frame end
  a_malformed_prefix: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.malformed |-> out_data.in_prefix && !out_data.frame_end
      && out_data.frame_length == '0)
    else $error("malformed result not shaped as a prefix byte");

  // nothing comes out after the error request has been taken
  a_silent_after_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.ready && out_data.malformed |=> !out_valid)
    else $error("result emitted after malformed stream");

  // a frame start carries no decoded length yet
  a_start_no_length: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_start |-> out_data.in_prefix && out_data.frame_length == '0)
    else $error("frame start with length");

  // a frame ending on a payload byte has a nonzero length
  a_payload_end_length: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_end && !out_data.in_prefix |-> out_data.frame_length != '0)
    else $error("payload frame end with zero length");

endmodule

### verif/tb_length_prefix_stream_deframer_top.sv
// self-checking testbench for length_prefix_stream_deframer_top: byte requests in,
// marked bytes out, checked against an in-bench prediction of the framing
// depends on lpd_pkg, lpd_if and the deframer rtl
module tb_length_prefix_stream_deframer_top;
  import lpd_pkg::*;

  // predicts the marked byte for every accepted input byte and checks the
  // results in order; holds its own copy of the framing state
  class deframe_scoreboard;
    result_t     pending_marks[$];
    count_t      hdr_pos;
    len_t        len_acc;
    len_t        bytes_left;
    bit          broken;
    int unsigned errors;
    int unsigned bytes_in;
    int unsigned bytes_dropped;
    int unsigned results_seen;
    int unsigned frames_done;
    int unsigned malformed_seen;

    function new();
      hdr_pos = '0;
      len_acc = '0;
      bytes_left = '0;
      broken = 1'b0;
      errors = 0;
      bytes_in = 0;
      bytes_dropped = 0;
      results_seen = 0;
      frames_done = 0;
      malformed_seen = 0;
    endfunction

    // accepted input byte: work out its marked result, if any
    function void predict_byte(logic [7:0] b);
      result_t     r;
      logic [39:0] wide;
      bytes_in++;
      if (broken) begin
        bytes_dropped++;
        return;
      end
      r = '0;
      r.out_byte = b;
      if (hdr_pos < PAYLOAD_PHASE) begin
        r.in_prefix = 1'b1;
        r.frame_start = (hdr_pos == count_t'(0));
        // place the byte at its weight in the 32-bit prefix, anything left
        // after dropping the legal length bits is oversized
        wide = 40'(b) << (8 * (PREFIX_BYTES - 1 - int'(hdr_pos)));
        if ((wide >> LENGTH_BITS) != 40'd0) begin
          broken = 1'b1;
          r.malformed = 1'b1;
          hdr_pos = '0;
          len_acc = '0;
          bytes_left = '0;
        end else begin
          len_acc = (hdr_pos == count_t'(0)) ? len_t'(b) : len_t'({len_acc, b});
          if (hdr_pos == count_t'(LAST_PREFIX_POS)) begin
            r.frame_length = len_acc;
            bytes_left = len_acc;
            if (len_acc == '0) begin
              r.frame_end = 1'b1;
              hdr_pos = '0;
            end else begin
              hdr_pos = PAYLOAD_PHASE;
            end
          end else begin
            hdr_pos = hdr_pos + count_t'(1);
          end
        end
      end else begin
        r.frame_length = len_acc;
        bytes_left = bytes_left - len_t'(1);
        if (bytes_left == '0) begin
          r.frame_end = 1'b1;
          hdr_pos = '0;
        end
      end
      pending_marks.push_back(r);
    endfunction

    function void compare_field(string name, longint unsigned exp_v, longint unsigned got_v);
      if (exp_v != got_v) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
        errors++;
      end
    endfunction

    // accepted result: compare against the oldest prediction
    function void check_result(result_t got);
      result_t want;
      results_seen++;
      if (pending_marks.size() == 0) begin
        $error("result with nothing expected: out_byte 0x%0h", got.out_byte);
        errors++;
        return;
      end
      want = pending_marks.pop_front();
      compare_field("out_byte", want.out_byte, got.out_byte);
      compare_field("in_prefix", want.in_prefix, got.in_prefix);
      compare_field("frame_start", want.frame_start, got.frame_start);
      compare_field("frame_end", want.frame_end, got.frame_end);
      compare_field("frame_length", want.frame_length, got.frame_length);
      compare_field("malformed", want.malformed, got.malformed);
      if (want.frame_end) frames_done++;
      if (want.malformed) malformed_seen++;
    endfunction

    function int unsigned pending();
      return pending_marks.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  lpd_rx_if  rx();
  lpd_res_if res();

  length_prefix_stream_deframer_top dut (
    .clk(clk),
    .rst(rst),
    .rx (rx),
    .res(res)
  );

  deframe_scoreboard sb;

  // quiet flags flip now and then so both sides get long stretches with no gaps
  bit tx_quiet;
  bit rx_quiet;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // per request wait drawn at random, or none during a quiet stretch
  function automatic int unsigned draw_gap(ref bit quiet);
    if ($urandom_range(0, 31) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, 17);
  endfunction

  // one byte request; returns at the edge where it was accepted, valid left high
  // so a back-to-back byte does not drop it in between
  task automatic send_byte(logic [7:0] b);
    int unsigned gap;
    gap = draw_gap(tx_quiet);
    if (gap > 0) begin
      rx.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    @(posedge clk);
    while (!rx.ready) @(posedge clk);
    sb.predict_byte(b);
  endtask

  // well-formed message: zero top byte, 24-bit big-endian length, random or fixed-fill payload
  task automatic send_frame(int unsigned len, logic [7:0] fill = 8'h00, bit random_fill = 1'b1);
    logic [23:0] l;
    l = 24'(len);
    send_byte(8'h00);
    send_byte(l[23:16]);
    send_byte(l[15:8]);
    send_byte(l[7:0]);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(random_fill ? 8'($urandom_range(0, 255)) : fill);
    end
  endtask

  // result side: stall at random, take one result per request
  initial begin
    result_t     got;
    int unsigned stall;
    res.ready <= 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      stall = draw_gap(rx_quiet);
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res.ready <= 1'b1;
      @(posedge clk);
      while (!res.valid) @(posedge clk);
      got.out_byte     = res.out_byte;
      got.in_prefix    = res.in_prefix;
      got.frame_start  = res.frame_start;
      got.frame_end    = res.frame_end;
      got.frame_length = res.frame_length;
      got.malformed    = res.malformed;
      sb.check_result(got);
    end
  end

  // main sequence
  initial begin
    int unsigned len;
    int unsigned guard;
    sb = new();
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    rst <= 1'b1;
    rx.valid <= 1'b0;
    rx.rx_byte <= 8'h00;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero-length frames back to back end on their last prefix byte
    send_frame(0);
    send_frame(0);
    // one-byte payload of all ones, then all zeros
    send_frame(1, 8'hff, 1'b0);
    send_frame(1, 8'h00, 1'b0);
    // alternating bit patterns in a short payload
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h03);
    send_byte(8'h55);
    send_byte(8'haa);
    send_byte(8'h80);

    // random: mostly short well-formed messages, now and then one that
    // needs the middle length byte; malformed is sticky so it comes last
    while (sb.bytes_in < 1000) begin
      case ($urandom_range(0, 39))
        0:       len = $urandom_range(256, 520);
        1, 2, 3: len = 0;
        default: len = $urandom_range(1, 24);
      endcase
      send_frame(len);
    end

    // oversized prefix: smallest offending top byte, on a fresh message
    send_byte(8'h01);
    // everything after it is taken and dropped
    repeat (30) send_byte(8'($urandom_range(0, 255)));
    rx.valid <= 1'b0;

    // drain what is still in flight, then wait on for strays
    guard = 0;
    while (sb.pending() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end

    $display("covered %0d bytes in, %0d results, %0d frames completed, %0d malformed",
             sb.bytes_in, sb.results_seen, sb.frames_done, sb.malformed_seen);
    $display("%0d bytes dropped after the stream broke, %0d mismatches",
             sb.bytes_dropped, sb.errors);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(8 * 1000000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### files.f
hdl/lpd_pkg.sv
hdl/lpd_if.sv
hdl/lpd_frame_tracker.sv
hdl/length_prefix_stream_deframer_top.sv
verif/tb_length_prefix_stream_deframer_top.sv
